// ----- src/oms_pkg.sv -----
// shared types and constants for the online mean and deviation block
package oms_pkg;

    // one input beat
    typedef struct packed {
        logic signed [31:0] sample;
        logic               last_sample;
    } t_item;

    // one finished data set
    typedef struct packed {
        logic signed [31:0] set_mean;
        logic [31:0]        std_deviation;
        logic [23:0]        sample_total;
    } t_result;

    // input queue geometry
    localparam int unsigned IQ_DEPTH = 2;
    localparam int unsigned IQ_PTR_W = 1;

    // last step index of each iterative phase
    localparam logic [5:0] LAST_MEAN_STEP = 6'd31;
    localparam logic [5:0] LAST_VAR_STEP  = 6'd63;
    localparam logic [5:0] LAST_ROOT_STEP = 6'd31;

endpackage

// ----- src/online_mean_stddev_top.sv -----
// top level of the online mean and standard deviation block
//
// Input side is a queue: drive sample and last_sample with push; a beat is
// taken on a clock edge where push is high and full is low. A two-entry
// input queue lets up to two beats wait while the arithmetic runs.
// Result side is a queue too: while empty is low the mean, standard deviation
// and sample total of the oldest finished data set are on the output ports;
// pop on an edge where empty is low takes it.
// Each sample passes through the update sequencer in order: it is taken, then
// 32 steps of the radix-2 divider give the mean correction, then the mean,
// deviation, multiply and accumulate states follow.
// A sample marked last adds 64 divider steps for the variance, 32 square
// root steps and a state to hand the result over; the result shows on the
// ports in the cycle after the handover.
// The divider and square root steps dominate; a new sample is taken only in idle.
// If the receiver does not pop, the finished result is held in the output
// register, the sequencer waits with the next result and the input queue
// fills, then full rises.
// Synchronous active-low reset empties both queues and clears the running
// count, mean and squared-deviation sum.
module online_mean_stddev_top
    import oms_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_sample,
    input  logic               i_last_sample,
    input  logic               pop,
    output logic               empty,
    output logic signed [31:0] o_set_mean,
    output logic [31:0]        o_std_deviation,
    output logic [23:0]        o_sample_total
);

    t_item   w_in_item;
    t_item   w_front_item;
    logic    w_front_valid;
    logic    w_front_pop;
    t_result w_back_res;
    logic    w_back_valid;
    logic    w_back_ready;
    t_result w_out_res;

    // pack the input beat
    assign w_in_item.sample      = i_sample;
    assign w_in_item.last_sample = i_last_sample;

    oms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_item       (w_in_item),
        .o_item_valid (w_front_valid),
        .i_item_pop   (w_front_pop),
        .o_item       (w_front_item)
    );

    oms_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_front_valid),
        .o_item_pop   (w_front_pop),
        .i_item       (w_front_item),
        .o_res_valid  (w_back_valid),
        .i_res_ready  (w_back_ready),
        .o_res        (w_back_res)
    );

    oms_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_back_valid),
        .o_res_ready (w_back_ready),
        .i_res       (w_back_res),
        .pop         (pop),
        .empty       (empty),
        .o_res       (w_out_res)
    );

    // unpack the result beat
    assign o_set_mean      = w_out_res.set_mean;
    assign o_std_deviation = w_out_res.std_deviation;
    assign o_sample_total  = w_out_res.sample_total;

endmodule

// ----- src/oms_front.sv -----
// front end: two-entry input queue that takes sample beats and hands them to the back end
module oms_front
    import oms_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  push,
    output logic  full,
    input  t_item i_item,
    output logic  o_item_valid,
    input  logic  i_item_pop,
    output t_item o_item
);

    t_item               r_mem [IQ_DEPTH];
    logic [IQ_PTR_W-1:0] r_wr_ptr;
    logic [IQ_PTR_W-1:0] r_rd_ptr;
    logic [IQ_PTR_W:0]   r_fill;
    logic [IQ_PTR_W-1:0] n_wr_ptr;
    logic [IQ_PTR_W-1:0] n_rd_ptr;
    logic [IQ_PTR_W:0]   n_fill;
    logic                w_wr;
    logic                w_rd;

    // handshake decode
    assign full         = (r_fill == (IQ_PTR_W+1)'(IQ_DEPTH));
    assign o_item_valid = (r_fill != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign w_wr         = push && !full;
    assign w_rd         = i_item_pop && o_item_valid;

    // pointer and fill update
    always_comb begin
        n_wr_ptr = w_wr ? r_wr_ptr + IQ_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = w_rd ? r_rd_ptr + IQ_PTR_W'(1) : r_rd_ptr;
        n_fill   = r_fill;
        if (w_wr && !w_rd) begin
            n_fill = r_fill + (IQ_PTR_W+1)'(1);
        end else if (w_rd && !w_wr) begin
            n_fill = r_fill - (IQ_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- src/oms_back.sv -----
// back end: welford update sequencer with a shared radix-2 divider and a bit-pair square root
module oms_back
    import oms_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 24
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    output logic    o_item_pop,
    input  t_item   i_item,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DIV  = 9'b000000010,
        S_MEAN = 9'b000000100,
        S_DEV  = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_ACC  = 9'b000100000,
        S_VDIV = 9'b001000000,
        S_SQRT = 9'b010000000,
        S_EMIT = 9'b100000000
    } t_state;

    t_state                  r_state, n_state;
    logic [5:0]              r_step, n_step;
    logic [COUNT_WIDTH-1:0]  r_count, n_count;
    logic [31:0]             r_mean, n_mean;
    logic [63:0]             r_qsum, n_qsum;
    logic [31:0]             r_x, n_x;
    logic                    r_last, n_last;
    logic                    r_dneg, n_dneg;
    logic [31:0]             r_dmag, n_dmag;
    logic [31:0]             r_d2mag, n_d2mag;
    logic [63:0]             r_prod, n_prod;
    logic [63:0]             r_div_d, n_div_d;
    logic [COUNT_WIDTH-1:0]  r_div_r, n_div_r;
    logic [63:0]             r_rad, n_rad;
    logic [35:0]             r_rem, n_rem;
    logic [31:0]             r_root, n_root;
    logic                    r_sat, n_sat;

    logic [32:0]             w_diff, w_diff_neg;
    logic [31:0]             w_diff_mag;
    logic [COUNT_WIDTH-1:0]  w_count_inc;
    logic [COUNT_WIDTH:0]    w_rem_sh, w_rem_sub;
    logic                    w_div_ge;
    logic [COUNT_WIDTH-1:0]  w_div_r_next;
    logic [63:0]             w_div_d_next;
    logic [32:0]             w_q33, w_q_signed, w_mean_new;
    logic [32:0]             w_d2, w_d2_neg;
    logic [63:0]             w_prod;
    logic [64:0]             w_acc;
    logic [63:0]             w_qsum_next;
    logic [35:0]             w_rt_sh, w_rt_trial, w_rt_sub;
    logic                    w_rt_ge;
    logic [31:0]             w_count32;

    // deviation of the new sample from the running mean
    assign w_diff      = {i_item.sample[31], i_item.sample} - {r_mean[31], r_mean};
    assign w_diff_neg  = -w_diff;
    assign w_diff_mag  = w_diff[32] ? w_diff_neg[31:0] : w_diff[31:0];
    assign w_count_inc = (r_count == '1) ? r_count : r_count + COUNT_WIDTH'(1);

    // one restoring divide step, divisor is the running count
    assign w_rem_sh     = {r_div_r, r_div_d[63]};
    assign w_rem_sub    = w_rem_sh - {1'b0, r_count};
    assign w_div_ge     = (w_rem_sh >= {1'b0, r_count});
    assign w_div_r_next = w_div_ge ? w_rem_sub[COUNT_WIDTH-1:0] : w_rem_sh[COUNT_WIDTH-1:0];
    assign w_div_d_next = {r_div_d[62:0], w_div_ge};

    // signed quotient applied to the mean, truncated toward zero
    assign w_q33      = {1'b0, r_div_d[31:0]};
    assign w_q_signed = r_dneg ? -w_q33 : w_q33;
    assign w_mean_new = {r_mean[31], r_mean} + w_q_signed;

    // deviation from the updated mean
    assign w_d2     = {r_x[31], r_x} - {r_mean[31], r_mean};
    assign w_d2_neg = -w_d2;

    // product and saturating accumulate
    assign w_prod      = r_dmag * r_d2mag;
    assign w_acc       = {1'b0, r_qsum} + {17'b0, r_prod[63:16]};
    assign w_qsum_next = w_acc[64] ? '1 : w_acc[63:0];

    // one square root step, two radicand bits at a time
    assign w_rt_sh    = {r_rem[33:0], r_rad[63:62]};
    assign w_rt_trial = {2'b00, r_root, 2'b01};
    assign w_rt_sub   = w_rt_sh - w_rt_trial;
    assign w_rt_ge    = (w_rt_sh >= w_rt_trial);

    // handshakes and result
    assign o_item_pop              = (r_state == S_IDLE) && i_item_valid;
    assign o_res_valid             = (r_state == S_EMIT);
    assign w_count32               = 32'(r_count);
    assign o_res.set_mean          = r_mean;
    assign o_res.std_deviation     = r_sat ? '1 : r_root;
    assign o_res.sample_total      = w_count32[23:0];

    // sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_count = r_count;
        n_mean  = r_mean;
        n_qsum  = r_qsum;
        n_x     = r_x;
        n_last  = r_last;
        n_dneg  = r_dneg;
        n_dmag  = r_dmag;
        n_d2mag = r_d2mag;
        n_prod  = r_prod;
        n_div_d = r_div_d;
        n_div_r = r_div_r;
        n_rad   = r_rad;
        n_rem   = r_rem;
        n_root  = r_root;
        n_sat   = r_sat;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_count = w_count_inc;
                    n_x     = i_item.sample;
                    n_last  = i_item.last_sample;
                    n_dneg  = w_diff[32];
                    n_dmag  = w_diff_mag;
                    n_div_d = {w_diff_mag, 32'b0};
                    n_div_r = '0;
                    n_step  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_div_d = w_div_d_next;
                n_div_r = w_div_r_next;
                n_step  = r_step + 6'd1;
                if (r_step == LAST_MEAN_STEP) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                n_mean  = w_mean_new[31:0];
                n_state = S_DEV;
            end
            S_DEV: begin
                n_d2mag = w_d2[32] ? w_d2_neg[31:0] : w_d2[31:0];
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = w_prod;
                n_state = S_ACC;
            end
            S_ACC: begin
                n_qsum = w_qsum_next;
                if (r_last) begin
                    n_div_d = w_qsum_next;
                    n_div_r = '0;
                    n_step  = '0;
                    n_state = S_VDIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_VDIV: begin
                n_div_d = w_div_d_next;
                n_div_r = w_div_r_next;
                n_step  = r_step + 6'd1;
                if (r_step == LAST_VAR_STEP) begin
                    n_rad   = {w_div_d_next[47:0], 16'b0};
                    n_sat   = |w_div_d_next[63:48];
                    n_rem   = '0;
                    n_root  = '0;
                    n_step  = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                n_rad  = {r_rad[61:0], 2'b00};
                n_rem  = w_rt_ge ? w_rt_sub : w_rt_sh;
                n_root = {r_root[30:0], w_rt_ge};
                n_step = r_step + 6'd1;
                if (r_step == LAST_ROOT_STEP) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_count = '0;
                    n_mean  = '0;
                    n_qsum  = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_mean  <= '0;
            r_qsum  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_mean  <= n_mean;
            r_qsum  <= n_qsum;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_x     <= n_x;
        r_last  <= n_last;
        r_dneg  <= n_dneg;
        r_dmag  <= n_dmag;
        r_d2mag <= n_d2mag;
        r_prod  <= n_prod;
        r_div_d <= n_div_d;
        r_div_r <= n_div_r;
        r_rad   <= n_rad;
        r_rem   <= n_rem;
        r_root  <= n_root;
        r_sat   <= n_sat;
    end

endmodule

// ----- src/oms_out.sv -----
// result register presented as the head of a queue
module oms_out
    import oms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    output logic    o_res_ready,
    input  t_result i_res,
    input  logic    pop,
    output logic    empty,
    output t_result o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;
    logic    w_load;

    // a new beat loads when the slot is free or drains this cycle
    assign o_res_ready = !r_valid || pop;
    assign w_load      = i_res_valid && o_res_ready;
    assign empty       = !r_valid;
    assign o_res       = r_res;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- src/oms_checker.sv -----
// port-level checks for the online mean and standard deviation block, bound to the top level
module oms_checker #(
    parameter int unsigned COUNT_WIDTH = 24
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic signed [31:0] i_sample,
    input logic               i_last_sample,
    input logic               pop,
    input logic               empty,
    input logic signed [31:0] o_set_mean,
    input logic [31:0]        o_std_deviation,
    input logic [23:0]        o_sample_total
);

    // reset leaves both queues empty
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // input queue only fills through a push
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push beat");

    // a waiting result holds until popped
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_set_mean)
            && $stable(o_std_deviation) && $stable(o_sample_total)))
        else $error("waiting result changed before pop");

    // a data set of one sample has no spread
    a_single_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_sample_total == 24'd1) && (COUNT_WIDTH <= 24))
            |-> (o_std_deviation == 32'd0))
        else $error("non-zero deviation for a single sample");

endmodule

bind online_mean_stddev_top oms_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_checker (.*);
